// File: hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared constants for the timestamp extension block
// widths of the request and result fields and the fixed scaling constants
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

	localparam int CPU_W    = 4;
	localparam int SAMPLE_W = 32;
	localparam int KHZ_W    = 24;
	localparam int TIME_W   = 64;
	localparam int SCALED_W = 52;

	// ns per second over hz per khz: sample * 1e9 / (khz * 1000) == sample * 1e6 / khz
	localparam int               SCALE_W   = 20;
	localparam logic [SCALE_W-1:0] SCALE_NUM = 20'd1000000;

	localparam logic [KHZ_W-1:0] KHZ_RESET = 24'd1000000;

	// 2^32 * 1e6, dividend of the wrap period
	localparam logic [SCALED_W-1:0] PERIOD_DIVIDEND = SCALED_W'(64'd1000000 << SAMPLE_W);

	localparam int DIV_STEPS = SCALED_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

// File: hw/rtl/tsc_div.sv
// ----------------------------------------------------------------------------
// tsc_div: radix-2 restoring divider
// one quotient bit per cycle, 52-bit dividend by 24-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_div
	import tsc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SCALED_W-1:0] dividend,
	input  wire logic [KHZ_W-1:0]    divisor,
	output logic                     done,
	output logic [SCALED_W-1:0]      quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [KHZ_W-1:0]     rem_q;
	logic [SCALED_W-1:0]  quo_q;

	logic [KHZ_W:0] trial;
	logic [KHZ_W:0] diff;
	logic           fits;

	// shift next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[SCALED_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[KHZ_W-1:0] : trial[KHZ_W-1:0];
			quo_q <= {quo_q[SCALED_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/tsc_wrap_extend_to_ns.sv
// ----------------------------------------------------------------------------
// tsc_wrap_extend_to_ns: per-cpu extension of a 32-bit cycle counter to ns
// scales each sample to ns by the configured frequency and adds a per-cpu
// wrap offset that grows by one wrap period whenever the scaled value drops
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// in        request    in_valid / in_stall   cpu_index, counter_sample
// out       result     out_valid / out_stall time_ns
// cfg       write      cfg_wr_en             cfg_wr_data (counter_khz)
//
// one request runs through the bit-serial divider once for scaling and, when the
// sample wrapped, once more for the wrap period; a new request is taken only
// after the result of the last one has been written to the result register.
// reset clears the frequency to 1 GHz and all per-cpu history through valid bits.
// in_stall is high while a request is in work; the result register holds
// under out_stall, and the last step waits until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_wrap_extend_to_ns
	import tsc_pkg::*;
#(
	parameter int NUM_CPUS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CPU_W-1:0]    cpu_index,
	input  wire logic [SAMPLE_W-1:0] counter_sample,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [TIME_W-1:0]        time_ns,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [KHZ_W-1:0]    cfg_wr_data
);

	localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IDX_N = 1 << CPU_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START1 = 3'd1;
	localparam logic [2:0] S_WAIT1  = 3'd2;
	localparam logic [2:0] S_START2 = 3'd3;
	localparam logic [2:0] S_WAIT2  = 3'd4;
	localparam logic [2:0] S_UPDATE = 3'd5;

	logic [2:0] state_q;

	logic [KHZ_W-1:0] khz_q;

	// request registers
	logic [IDX_W-1:0]    idx_q;
	logic [KHZ_W-1:0]    divisor_q;
	logic [SCALED_W-1:0] product_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [TIME_W-1:0]   offset_q;

	// per-cpu history: memory plus valid bits that reset clears
	logic [SCALED_W-1:0] last_mem [NUM_CPUS];
	logic [TIME_W-1:0]   off_mem  [NUM_CPUS];
	logic [NUM_CPUS-1:0] hist_vld_q;
	logic [SCALED_W-1:0] last_rd_q;
	logic [TIME_W-1:0]   off_rd_q;

	logic [SCALED_W-1:0] last_eff;
	logic [TIME_W-1:0]   off_eff;

	// result register
	logic                out_valid_q;
	logic [TIME_W-1:0]   time_ns_q;

	// shared divider
	logic                div_start;
	logic [SCALED_W-1:0] div_dividend;
	logic                div_done;
	logic [SCALED_W-1:0] div_quo;

	logic                 accept;
	logic                 out_free;
	logic [IDX_W-1:0]     idx_map [IDX_N];
	logic [IDX_W-1:0]     idx_in;
	logic [SCALED_W-1:0]  product;

	// cpu index folds into range, table worked out at elaboration
	for (genvar g = 0; g < IDX_N; g++) begin : g_idx_map
		localparam int FOLD = g % NUM_CPUS;
		assign idx_map[g] = IDX_W'(FOLD);
	end

	assign idx_in   = idx_map[cpu_index];
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// sample * 1e6, exactly 52 bits
	assign product = SCALED_W'(counter_sample) * SCALED_W'(SCALE_NUM);

	// a cpu never written reads as zero history
	assign last_eff = hist_vld_q[idx_q] ? last_rd_q : '0;
	assign off_eff  = hist_vld_q[idx_q] ? off_rd_q : '0;

	assign div_start    = (state_q == S_START1) || (state_q == S_START2);
	assign div_dividend = (state_q == S_START2) ? PERIOD_DIVIDEND : product_q;

	tsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// frequency register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			khz_q <= KHZ_RESET;
		end else if (cfg_wr_en) begin
			khz_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_START1;
				end
				S_START1: begin
					state_q <= S_WAIT1;
				end
				S_WAIT1: begin
					if (div_done) begin
						state_q <= (div_quo < last_eff) ? S_START2 : S_UPDATE;
					end
				end
				S_START2: begin
					state_q <= S_WAIT2;
				end
				S_WAIT2: begin
					if (div_done) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= idx_in;
			// zero frequency counts as 1 khz
			divisor_q <= (khz_q == '0) ? KHZ_W'(1) : khz_q;
			product_q <= product;
			last_rd_q <= last_mem[idx_in];
			off_rd_q  <= off_mem[idx_in];
		end
		if (state_q == S_WAIT1 && div_done) begin
			scaled_q <= div_quo;
			offset_q <= off_eff;
		end
		// wrap detected: add the period
		if (state_q == S_WAIT2 && div_done) begin
			offset_q <= offset_q + TIME_W'(div_quo);
		end
	end

	// history write back
	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE && out_free) begin
			last_mem[idx_q] <= scaled_q;
			off_mem[idx_q]  <= offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (state_q == S_UPDATE && out_free) begin
			hist_vld_q[idx_q] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_UPDATE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE && out_free) begin
			time_ns_q <= TIME_W'(scaled_q) + offset_q;
		end
	end

	assign out_valid = out_valid_q;
	assign time_ns   = time_ns_q;

endmodule

`default_nettype wire

// File: test/tsc_wrap_extend_to_ns_tb.sv
// ----------------------------------------------------------------------------
// tsc_wrap_extend_to_ns_tb: regression for the per-cpu counter extension block
// drives sample requests under random idling and stalls, predicts every
// extended ns time in the bench and compares each result in order, and walks
// the frequency register through zero, low, high and full-scale settings
// ----------------------------------------------------------------------------

module tsc_wrap_extend_to_ns_tb
	import tsc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NUM_CPUS       = 16;
	localparam int          HALF_PERIOD    = 6;
	localparam int          RESET_CYCLES   = 8;
	localparam int          LONG_HOLD      = 300;   // receiver hold-off for back-pressure
	localparam int          STUCK_LIMIT    = 4000;  // cycles with no transfer at all
	localparam int          CFG_SETTLE     = 8;     // idle cycles before a register write
	localparam int          DRAIN_CYCLES   = 150;   // quiet time after the last result
	localparam int          STAGE_REQS     = 150;
	localparam int          ROLLOVER_REQS  = 180;   // back-to-back wraps on one cpu
	localparam logic [63:0] NS_PER_S       = 64'd1_000_000_000;
	localparam logic [63:0] WRAP_DIVIDEND  = 64'd4_294_967_296 * NS_PER_S;

	typedef enum logic {ROW_SAMPLE, ROW_KHZ} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [KHZ_W-1:0]      khz;
		logic [CPU_W-1:0]      cpu;
		logic [SAMPLE_W-1:0]   sample;
		logic                  typed;
		logic [TIME_W-1:0]     want;
	} dir_row_t;

	// directed rows; at reset the counter runs at 1 GHz, so ns == sample and one
	// wrap adds exactly 2^32, which makes the early results easy to type in
	localparam dir_row_t DIRECTED [0:24] = '{
		'{ROW_SAMPLE, 24'd0,       4'd0,  32'h0000_0000, 1'b1, 64'h0_0000_0000},
		'{ROW_SAMPLE, 24'd0,       4'd0,  32'hffff_ffff, 1'b1, 64'h0_ffff_ffff},
		'{ROW_SAMPLE, 24'd0,       4'd0,  32'h0000_0005, 1'b1, 64'h1_0000_0005},
		'{ROW_SAMPLE, 24'd0,       4'd15, 32'hffff_ffff, 1'b1, 64'h0_ffff_ffff},
		'{ROW_SAMPLE, 24'd0,       4'd15, 32'hffff_ffff, 1'b1, 64'h0_ffff_ffff},
		'{ROW_SAMPLE, 24'd0,       4'd15, 32'h0000_0000, 1'b1, 64'h1_0000_0000},
		'{ROW_SAMPLE, 24'd0,       4'd10, 32'haaaa_aaaa, 1'b1, 64'h0_aaaa_aaaa},
		'{ROW_SAMPLE, 24'd0,       4'd5,  32'h5555_5555, 1'b1, 64'h0_5555_5555},
		'{ROW_SAMPLE, 24'd0,       4'd10, 32'h5555_5555, 1'b1, 64'h1_5555_5555},
		'{ROW_SAMPLE, 24'd0,       4'd5,  32'haaaa_aaaa, 1'b1, 64'h0_aaaa_aaaa},
		'{ROW_SAMPLE, 24'd0,       4'd0,  32'h0000_0004, 1'b1, 64'h2_0000_0004},
		'{ROW_SAMPLE, 24'd0,       4'd3,  32'h8000_0000, 1'b1, 64'h0_8000_0000},
		'{ROW_SAMPLE, 24'd0,       4'd3,  32'h7fff_ffff, 1'b1, 64'h1_7fff_ffff},
		// zero frequency falls back to 1 kHz
		'{ROW_KHZ,    24'd0,       4'd0,  32'h0,         1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd1,  32'hffff_ffff, 1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd1,  32'h0000_0001, 1'b0, 64'h0},
		// full-scale register, history from the old rate is kept as is
		'{ROW_KHZ,    24'hff_ffff, 4'd0,  32'h0,         1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd1,  32'hffff_ffff, 1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd2,  32'h1234_5678, 1'b0, 64'h0},
		'{ROW_KHZ,    24'd1000,    4'd0,  32'h0,         1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd2,  32'h0001_0000, 1'b0, 64'h0},
		'{ROW_KHZ,    24'd10000000, 4'd0, 32'h0,         1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd4,  32'hdead_beef, 1'b0, 64'h0},
		'{ROW_KHZ,    24'd1,       4'd0,  32'h0,         1'b0, 64'h0},
		'{ROW_SAMPLE, 24'd0,       4'd4,  32'h0000_0001, 1'b0, 64'h0}
	};

	// dut ports; the inputs are known from time zero
	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic [CPU_W-1:0]    cpu_index      = '0;
	logic [SAMPLE_W-1:0] counter_sample = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic [TIME_W-1:0]   time_ns;
	logic                cfg_wr_en      = 1'b0;
	logic [KHZ_W-1:0]    cfg_wr_data    = '0;

	// bench copy of the block state
	logic [KHZ_W-1:0]    cfg_khz;
	logic [SCALED_W-1:0] hist_scaled [NUM_CPUS];
	logic [TIME_W-1:0]   hist_offset [NUM_CPUS];

	// ns times still owed by the block, oldest first
	logic [TIME_W-1:0]   pending_times [$];

	// stimulus side bookkeeping: last sample sent per cpu
	logic [SAMPLE_W-1:0] stim_last [NUM_CPUS];

	int unsigned mismatches       = 0;
	int unsigned results_checked  = 0;
	int unsigned requests_sent    = 0;
	int unsigned khz_settings     = 0;
	int unsigned stuck_cycles     = 0;
	logic        idle_on          = 1'b0;
	logic        long_hold_pending = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	tsc_wrap_extend_to_ns #(
		.NUM_CPUS(NUM_CPUS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cpu_index     (cpu_index),
		.counter_sample(counter_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.time_ns       (time_ns),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// scale one sample to ns at the current rate, extend it with the cpu's
	// wrap offset and update that cpu's history; returns the extended time
	function automatic logic [TIME_W-1:0] extend_sample(input logic [CPU_W-1:0] cpu,
			input logic [SAMPLE_W-1:0] sample);
		logic [63:0]         freq_hz;
		logic [63:0]         quotient;
		logic [SCALED_W-1:0] scaled;
		int unsigned         slot;
		// a zero register reads as 1 kHz
		freq_hz  = (cfg_khz == '0) ? 64'd1000 : 64'(cfg_khz) * 64'd1000;
		slot     = int'(cpu) % NUM_CPUS;
		quotient = (64'(sample) * NS_PER_S) / freq_hz;
		scaled   = quotient[SCALED_W-1:0];
		// a drop in scaled time means the raw counter rolled over
		if (scaled < hist_scaled[slot])
			hist_offset[slot] = hist_offset[slot] + WRAP_DIVIDEND / freq_hz;
		hist_scaled[slot] = scaled;
		return 64'(scaled) + hist_offset[slot];
	endfunction

	// mostly a counter that keeps running per cpu, with jumps, repeats,
	// small steps back and the extremes mixed in
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [CPU_W-1:0] cpu);
		logic [SAMPLE_W-1:0] prev;
		int unsigned         roll;
		prev = stim_last[cpu];
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return prev + SAMPLE_W'($urandom_range(1, 1 << 20));
		else if (roll < 68)
			return prev + SAMPLE_W'($urandom());
		else if (roll < 83)
			return SAMPLE_W'($urandom());
		else if (roll < 89)
			return prev;
		else if (roll < 95)
			return prev - SAMPLE_W'($urandom_range(1, 1000));
		else if (roll[0])
			return '1;
		else
			return '0;
	endfunction

	// offer one request and hold it until the block takes it; valid is left
	// high so a following request goes out back to back
	task automatic offer_sample(input logic [CPU_W-1:0] cpu, input logic [SAMPLE_W-1:0] sample,
			input logic typed, input logic [TIME_W-1:0] want);
		logic [TIME_W-1:0] predicted;
		@(negedge clk);
		in_valid       <= 1'b1;
		cpu_index      <= cpu;
		counter_sample <= sample;
		do
			@(posedge clk);
		while (in_stall);
		// accepted at this edge: predict now, while the rate is the one in use
		predicted = extend_sample(cpu, sample);
		pending_times.push_back(typed ? want : predicted);
		requests_sent++;
	endtask

	// random gap on the request side
	task automatic maybe_idle_sender();
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// register write with the block drained and idle
	task automatic set_counter_khz(input logic [KHZ_W-1:0] khz);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_times.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= khz;
		@(posedge clk);
		cfg_khz = khz;
		khz_settings++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				hold_left = LONG_HOLD;
			end else if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				hold_left = $urandom_range(1, 8);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	// result checker: every accepted result against the oldest owed time
	always @(posedge clk) begin
		logic [TIME_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_times.size() == 0) begin
				$error("time_ns %h arrived with no request outstanding", time_ns);
				mismatches++;
			end else begin
				want = pending_times.pop_front();
				results_checked++;
				if (time_ns !== want) begin
					$error("time_ns mismatch: expected %h, actual %h", want, time_ns);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long without any request or result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$error("no request or result moved for %0d cycles", STUCK_LIMIT);
			$display("tsc_wrap_extend_to_ns regression: fail");
			$finish;
		end
	end

	initial begin
		logic [KHZ_W-1:0]    stage_khz [8];
		logic [CPU_W-1:0]    cpu;
		logic [SAMPLE_W-1:0] sample;

		cfg_khz = KHZ_RESET;
		for (int i = 0; i < NUM_CPUS; i++) begin
			hist_scaled[i] = '0;
			hist_offset[i] = '0;
			stim_last[i]   = '0;
		end

		// reset once, released away from the rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n  <= 1'b1;
		idle_on = 1'b1;

		// directed part
		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_KHZ)
				set_counter_khz(DIRECTED[r].khz);
			else begin
				maybe_idle_sender();
				offer_sample(DIRECTED[r].cpu, DIRECTED[r].sample, DIRECTED[r].typed,
					DIRECTED[r].want);
				stim_last[DIRECTED[r].cpu] = DIRECTED[r].sample;
			end
		end

		// random part: one frequency per stage, extremes among them
		stage_khz[0] = KHZ_RESET;
		stage_khz[1] = KHZ_W'($urandom_range(1000, 10000000));
		stage_khz[2] = 24'd10000000;
		stage_khz[3] = 24'd1000;
		stage_khz[4] = 24'hff_ffff;
		stage_khz[5] = KHZ_W'($urandom());
		stage_khz[6] = 24'd1;
		stage_khz[7] = KHZ_W'($urandom_range(1000, 10000000));

		for (int stage_idx = 0; stage_idx < 8; stage_idx++) begin
			set_counter_khz(stage_khz[stage_idx]);
			for (int n = 0; n < STAGE_REQS; n++) begin
				// idling switches on and off in stretches; the last stage runs flat out
				if (n % 40 == 0)
					idle_on = (stage_idx != 7) && ($urandom_range(0, 3) != 0);
				// one long receiver hold-off while requests keep coming, so the
				// result register fills and the input side has to stall
				if (stage_idx == 1 && n == 50)
					long_hold_pending = 1'b1;
				cpu    = CPU_W'($urandom_range(0, NUM_CPUS - 1));
				sample = pick_sample(cpu);
				maybe_idle_sender();
				offer_sample(cpu, sample, 1'b0, '0);
				stim_last[cpu] = sample;
			end
		end

		// wrap run: at 1 kHz each wrap adds about 2^52, so a strictly
		// falling sample on one cpu wraps every time and drives the offset
		// up in large steps
		idle_on = 1'b0;
		set_counter_khz('0);
		for (int k = 0; k < ROLLOVER_REQS; k++)
			offer_sample(4'd9, 32'hffff_ffff - SAMPLE_W'(k), 1'b0, '0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_times.size() != 0)
			@(posedge clk);
		// catch any stray extra result
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests on all 16 cpus over %0d frequency settings,",
			requests_sent, khz_settings);
		$display("zero and full-scale included; checked %0d extended times, with a long wrap run",
			results_checked);
		if (mismatches == 0)
			$display("tsc_wrap_extend_to_ns regression: pass");
		else
			$display("tsc_wrap_extend_to_ns regression: fail");
		$finish;
	end

endmodule
